/* src/sem_pkg.sv */
package sem_pkg;

    localparam int PIXEL_BITS    = 8;
    localparam int WIDTH_BITS    = 11;
    localparam int ROW_BITS      = 12;
    localparam int COL_OUT_BITS  = 10;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int EXT_BITS      = 13;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = 12'd480;

    localparam logic [PIXEL_BITS-1:0] GRAD_MAX = 8'd255;

    // Square root of a 17-bit sum: one result bit per step.
    localparam int SQ_BITS    = 17;
    localparam int ROOT_STEPS = 9;
    localparam int STEP_BITS  = 4;

    typedef struct packed {
        logic accept;
        logic update;
        logic select;
        logic square;
        logic root_step;
        logic out_load;
    } sem_cmd_t;

    typedef struct packed {
        logic any_left;
        logic root_done;
    } sem_sts_t;

endpackage

/* src/sobel_edge_magnitude.sv */
// Channel   Handshake           Payload
// input     s_valid / s_ready   s_pixel
// result    m_valid / m_ready   m_column, m_row_index, m_magnitude,
//                               m_last_of_run, m_end_of_frame
// config    cfg_we              cfg_index, cfg_wdata
//
// Each item causes 0 to 4 results; each result is selected, squared, taken
// through the 9-step square root unit and then offered until m_ready is high.
// One pixel is in work at a time.
// Reset (aresetn low at a clock edge) clears counters, window and state;
// the line stores keep undefined contents until written.
// A stalled result holds all m_ fields; s_ready stays low until the last
// result of the current pixel has been transferred.
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // pixel input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sem_pkg::PIXEL_BITS-1:0]    s_pixel,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sem_pkg::COL_OUT_BITS-1:0]  m_column,
    output logic [sem_pkg::ROW_BITS-1:0]      m_row_index,
    output logic [sem_pkg::PIXEL_BITS-1:0]    m_magnitude,
    output logic                              m_last_of_run,
    output logic                              m_end_of_frame,
    // register writes (frame restarts on a write to the width or height register)
    input  logic                              cfg_we,
    input  logic [sem_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [sem_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

    sem_pkg::sem_cmd_t cmd;
    sem_pkg::sem_sts_t sts;

    // Sequencer: transfer, store update, then per result select, square,
    // root and offer.
    sem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Line stores, 3x3 window, Sobel kernels and square root unit.
    sem_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_pixel        (s_pixel),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .m_column       (m_column),
        .m_row_index    (m_row_index),
        .m_magnitude    (m_magnitude),
        .m_last_of_run  (m_last_of_run),
        .m_end_of_frame (m_end_of_frame)
    );

endmodule

/* src/sem_ctrl.sv */
module sem_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  sem_pkg::sem_sts_t sts,
    output sem_pkg::sem_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SELECT,
        ST_SQUARE,
        ST_ROOT,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        cmd           = '0;
        cmd.accept    = (state_reg == ST_IDLE) && s_valid;
        cmd.update    = (state_reg == ST_UPDATE);
        cmd.select    = (state_reg == ST_SELECT) && sts.any_left;
        cmd.square    = (state_reg == ST_SQUARE);
        cmd.root_step = (state_reg == ST_ROOT) && !sts.root_done;
        cmd.out_load  = (state_reg == ST_ROOT) && sts.root_done;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_SELECT;
            ST_SELECT: state_next = sts.any_left ? ST_SQUARE : ST_IDLE;
            ST_SQUARE: state_next = ST_ROOT;
            ST_ROOT:   if (sts.root_done) state_next = ST_OUT;
            ST_OUT:    if (m_ready) state_next = ST_SELECT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    // One item at a time: never take input while a result is offered.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while result pending");

    // An accepted pixel is always followed by the store update.
    a_accept_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.update) else $error("update missing after transfer");
`endif

endmodule

/* src/sem_dp.sv */
module sem_dp #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sem_pkg::sem_cmd_t                     cmd,
    output sem_pkg::sem_sts_t                     sts,
    input  logic [sem_pkg::PIXEL_BITS-1:0]        s_pixel,
    input  logic                                  cfg_we,
    input  logic [sem_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [sem_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    output logic [sem_pkg::COL_OUT_BITS-1:0]      m_column,
    output logic [sem_pkg::ROW_BITS-1:0]          m_row_index,
    output logic [sem_pkg::PIXEL_BITS-1:0]        m_magnitude,
    output logic                                  m_last_of_run,
    output logic                                  m_end_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PB = sem_pkg::PIXEL_BITS;
    localparam int RB = sem_pkg::ROW_BITS;
    localparam int EB = sem_pkg::EXT_BITS;
    localparam int SB = sem_pkg::SQ_BITS;

    typedef logic [PB-1:0] pix_t;

    // Line stores
    pix_t line_prev  [MAX_WIDTH];
    pix_t line_prev2 [MAX_WIDTH];

    logic [sem_pkg::WIDTH_BITS-1:0] width_reg;
    logic [RB-1:0]                  height_reg;
    logic [CW-1:0]                  col_reg;
    logic [RB-1:0]                  row_reg;
    pix_t                           pix_reg, rd_a_reg, rd_b_reg;
    pix_t                           win_reg [9];

    logic [CW-1:0] cur_col_reg;
    logic [RB-1:0] cur_row_reg;
    logic          col_is1_reg, row_is1_reg;
    logic [3:0]    mask_reg;

    pix_t          ax_reg, ay_reg;
    logic [CW-1:0] tag_col_reg;
    logic [RB-1:0] tag_row_reg;
    logic          tag_last_reg, tag_eof_reg;

    logic [SB-1:0]                  val_reg;
    logic [SB-1:0]                  root_reg;
    logic [SB-1:0]                  bit_reg;
    logic [sem_pkg::STEP_BITS-1:0]  step_reg;

    logic [CW-1:0] out_col_reg;
    logic [RB-1:0] out_row_reg;
    pix_t          out_mag_reg;
    logic          out_last_reg, out_eof_reg;

    // Effective frame size
    logic [EB-1:0] w_eff, h_eff, c_ext;
    logic          c_first, c_last, r_first, r_last;

    always_comb begin
        w_eff = EB'(width_reg);
        if (w_eff < EB'(2)) w_eff = EB'(2);
        if (w_eff > EB'(MAX_WIDTH)) w_eff = EB'(MAX_WIDTH);
        h_eff = EB'(height_reg);
        if (h_eff < EB'(2)) h_eff = EB'(2);
        c_ext   = EB'(col_reg);
        c_first = (col_reg == '0);
        c_last  = (c_ext >= w_eff - EB'(1));
        r_first = (row_reg == '0);
        r_last  = (EB'(row_reg) >= h_eff - EB'(1));
    end

    // Result selection: lowest pending kind first
    logic [1:0] kind;
    logic [3:0] mask_clr;
    always_comb begin
        priority if (mask_reg[0]) kind = 2'd0;
        else if (mask_reg[1])     kind = 2'd1;
        else if (mask_reg[2])     kind = 2'd2;
        else                      kind = 2'd3;
        mask_clr = mask_reg & ~(4'b0001 << kind);
    end

    function automatic pix_t pick(input pix_t a0, input pix_t a1, input pix_t a2,
                                  input logic [1:0] s);
        pix_t v;
        unique case (s)
            2'd0:    v = a0;
            2'd1:    v = a1;
            default: v = a2;
        endcase
        return v;
    endfunction

    logic [1:0] rsel [3];
    logic [1:0] csel [3];
    pix_t       rowv [3][3];
    pix_t       nb   [3][3];
    logic signed [11:0] gx, gy;
    logic [11:0] gx_abs, gy_abs;
    pix_t        gx_cl, gy_cl;

    always_comb begin
        if (kind[1]) begin
            rsel[0] = 2'd1; rsel[1] = 2'd2; rsel[2] = 2'd1;
        end else begin
            rsel[0] = row_is1_reg ? 2'd2 : 2'd0; rsel[1] = 2'd1; rsel[2] = 2'd2;
        end
        if (kind[0]) begin
            csel[0] = 2'd1; csel[1] = 2'd2; csel[2] = 2'd1;
        end else begin
            csel[0] = col_is1_reg ? 2'd2 : 2'd0; csel[1] = 2'd1; csel[2] = 2'd2;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rowv[i][j] = pick(win_reg[j], win_reg[3 + j], win_reg[6 + j], rsel[i]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                nb[i][j] = pick(rowv[i][0], rowv[i][1], rowv[i][2], csel[j]);
            end
        end
        gx = ($signed({4'd0, nb[0][2]}) + $signed({3'd0, nb[1][2], 1'b0})
              + $signed({4'd0, nb[2][2]}))
           - ($signed({4'd0, nb[0][0]}) + $signed({3'd0, nb[1][0], 1'b0})
              + $signed({4'd0, nb[2][0]}));
        gy = ($signed({4'd0, nb[2][0]}) + $signed({3'd0, nb[2][1], 1'b0})
              + $signed({4'd0, nb[2][2]}))
           - ($signed({4'd0, nb[0][0]}) + $signed({3'd0, nb[0][1], 1'b0})
              + $signed({4'd0, nb[0][2]}));
        gx_abs = gx[11] ? 12'(-gx) : 12'(gx);
        gy_abs = gy[11] ? 12'(-gy) : 12'(gy);
        gx_cl  = (gx_abs > 12'(sem_pkg::GRAD_MAX)) ? sem_pkg::GRAD_MAX : gx_abs[PB-1:0];
        gy_cl  = (gy_abs > 12'(sem_pkg::GRAD_MAX)) ? sem_pkg::GRAD_MAX : gy_abs[PB-1:0];
    end

    // Square root step
    logic [SB:0] trial;
    logic        fits;
    always_comb begin
        trial = {1'b0, root_reg} + {1'b0, bit_reg};
        fits  = ({1'b0, val_reg} >= trial);
    end

    assign sts.any_left  = (mask_reg != '0);
    assign sts.root_done = (step_reg == sem_pkg::STEP_BITS'(sem_pkg::ROOT_STEPS));

    // Line stores: read on transfer, write back during update
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_a_reg <= line_prev2[col_reg];
            rd_b_reg <= line_prev[col_reg];
        end
        if (cmd.update) begin
            line_prev2[col_reg] <= rd_b_reg;
            line_prev[col_reg]  <= pix_reg;
        end
    end

    // Control state: configuration, counters, window, pending results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= sem_pkg::WIDTH_RESET;
            height_reg <= sem_pkg::HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            mask_reg   <= '0;
            step_reg   <= '0;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end else begin
            if (cfg_we && (cfg_index == sem_pkg::CFG_IMAGE_WIDTH ||
                           cfg_index == sem_pkg::CFG_IMAGE_HEIGHT)) begin
                if (cfg_index == sem_pkg::CFG_IMAGE_WIDTH) begin
                    width_reg <= cfg_wdata[sem_pkg::WIDTH_BITS-1:0];
                end else begin
                    height_reg <= cfg_wdata;
                end
                col_reg <= '0;
                row_reg <= '0;
            end else if (cmd.update) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[3*j]     <= win_reg[3*j + 1];
                    win_reg[3*j + 1] <= win_reg[3*j + 2];
                end
                win_reg[2] <= rd_a_reg;
                win_reg[5] <= rd_b_reg;
                win_reg[8] <= pix_reg;
                mask_reg <= {r_last & c_last, r_last & !c_first,
                             !r_first & c_last, !r_first & !c_first};
                if (c_last) begin
                    col_reg <= '0;
                    row_reg <= r_last ? '0 : row_reg + RB'(1);
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end else if (cmd.select) begin
                mask_reg <= mask_clr;
            end
            if (cmd.square) begin
                step_reg <= '0;
            end else if (cmd.root_step) begin
                step_reg <= step_reg + sem_pkg::STEP_BITS'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) pix_reg <= s_pixel;
        if (cmd.update) begin
            cur_col_reg <= col_reg;
            cur_row_reg <= row_reg;
            col_is1_reg <= (col_reg == CW'(1));
            row_is1_reg <= (row_reg == RB'(1));
        end
        if (cmd.select) begin
            ax_reg       <= gx_cl;
            ay_reg       <= gy_cl;
            tag_col_reg  <= kind[0] ? cur_col_reg : cur_col_reg - CW'(1);
            tag_row_reg  <= kind[1] ? cur_row_reg : cur_row_reg - RB'(1);
            tag_last_reg <= (mask_clr == '0);
            tag_eof_reg  <= (kind == 2'd3);
        end
        if (cmd.square) begin
            val_reg  <= SB'({8'd0, ax_reg} * {8'd0, ax_reg})
                      + SB'({8'd0, ay_reg} * {8'd0, ay_reg});
            root_reg <= '0;
            bit_reg  <= SB'(1) << (SB - 1);
        end else if (cmd.root_step) begin
            if (fits) begin
                val_reg  <= val_reg - trial[SB-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.out_load) begin
            out_col_reg  <= tag_col_reg;
            out_row_reg  <= tag_row_reg;
            out_mag_reg  <= (root_reg > SB'(sem_pkg::GRAD_MAX)) ? sem_pkg::GRAD_MAX
                                                                : root_reg[PB-1:0];
            out_last_reg <= tag_last_reg;
            out_eof_reg  <= tag_eof_reg;
        end
    end

    logic [CW+sem_pkg::COL_OUT_BITS-1:0] col_wide;
    assign col_wide       = {{sem_pkg::COL_OUT_BITS{1'b0}}, out_col_reg};
    assign m_column       = col_wide[sem_pkg::COL_OUT_BITS-1:0];
    assign m_row_index    = out_row_reg;
    assign m_magnitude    = out_mag_reg;
    assign m_last_of_run  = out_last_reg;
    assign m_end_of_frame = out_eof_reg;

`ifndef ASSERT_OFF
    // Each selection retires exactly one pending result.
    a_one_retired: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.select |=> ($countones(mask_reg) == $countones($past(mask_reg)) - 1))
        else $error("selection did not retire one result");

    // Frame end marks the final result of its pixel.
    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.out_load) && out_eof_reg |-> out_last_reg)
        else $error("frame end without run end");
`endif

endmodule
